// ----- hdl/glif_pkg.sv -----
package glif_pkg;

   localparam int DEFAULT_MAX_GAP = 63;
   localparam int SAMPLE_W        = 32;
   // The difference of two samples needs one bit more than a sample.
   localparam int DIV_W           = SAMPLE_W + 1;
   localparam int DIV_CNT_W       = $clog2(DIV_W);

   typedef enum logic [0:0] {
      CSR_MARKER_MODE  = 1'b0,
      CSR_MARKER_VALUE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic gap_inc;
      logic div_start;
      logic div_step;
      logic acc_load;
      logic emit_fill;
      logic emit_cur;
      logic emit_flush;
   } dp_cmd_type;

   typedef struct packed {
      logic missing;
      logic column_end;
      logic have_valid;
      logic gap_zero;
      logic gap_full;
      logic div_done;
      logic fill_last;
      logic flush_last;
      logic slot_free;
   } dp_status_type;

endpackage

// ----- hdl/gap_linear_interpolation_fill.sv -----
// Gap filler for one column of a Q16.16 time series, one sample per input item.
// The req_ channel carries sample, is_nan and column_end; the rsp_ channel carries
// value, filled, error, last_of_run and column_done. Both use valid and stall.
// A missing sample (the NaN flag, or in marker mode instead equality with the
// marker) is held as a count and produces no result item unless it overflows the
// gap or ends the column. The sample that closes a gap releases the fill items and
// then itself. Inner gaps are interpolated, leading gaps are filled with the closing
// sample, trailing gaps with the last valid sample. Overflowing gaps and all-missing
// columns are flushed flat with error set. The block works on one item at a time.
// For an inner gap the bit-serial divider sets the step size once per gap, after
// which the fill values come out one per cycle while rsp_ does not stall. The
// result item of a sample with no open gap is captured from req_, then written to
// the output register from the decide state, or from S_CUR once it is free.
// A result waiting in the output register does not block the next input item;
// a stall on rsp_ freezes the item in progress until the register drains. Reset
// synchronously clears the column state, configuration and output valid flag.
// The user writes configuration through csr_ only while the block is idle (unchecked).
module gap_linear_interpolation_fill import glif_pkg::*; #(
   parameter int MAX_GAP = DEFAULT_MAX_GAP
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_is_nan,
   input  logic                       req_column_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   output logic                       rsp_filled,
   output logic                       rsp_error,
   output logic                       rsp_last_of_run,
   output logic                       rsp_column_done,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [SAMPLE_W-1:0]        csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller sequences each item; the datapath holds the column state,
   // the divider, the fill accumulator and the output register.
   glif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   glif_dp #(
      .MAX_GAP (MAX_GAP)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .req_is_nan      (req_is_nan),
      .req_column_end  (req_column_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_filled      (rsp_filled),
      .rsp_error       (rsp_error),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_column_done (rsp_column_done),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ----- hdl/glif_dp.sv -----
module glif_dp import glif_pkg::*; #(
   parameter int MAX_GAP = DEFAULT_MAX_GAP
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_is_nan,
   input  logic                       req_column_end,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [SAMPLE_W-1:0]        csr_wdata,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   output logic                       rsp_filled,
   output logic                       rsp_error,
   output logic                       rsp_last_of_run,
   output logic                       rsp_column_done,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status
);

   localparam int GAP_W = $clog2(MAX_GAP + 1);
   localparam int DEN_W = GAP_W + 1;

   logic                       mode_ff;
   logic [SAMPLE_W-1:0]        marker_ff;
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic                       end_ff;
   logic                       missing_ff;
   logic signed [SAMPLE_W-1:0] last_ff;
   logic                       have_ff;
   logic [GAP_W-1:0]           gap_ff;
   logic [GAP_W-1:0]           idx_ff;
   logic [DIV_W-1:0]           div_num_ff;
   logic [DEN_W-1:0]           div_rem_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;
   logic                       neg_ff;
   logic [DIV_W-1:0]           acc_q_ff;
   logic [DEN_W-1:0]           acc_r_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_value_ff;
   logic                       rsp_filled_ff;
   logic                       rsp_error_ff;
   logic                       rsp_last_ff;
   logic                       rsp_done_ff;

   logic                       req_missing;
   logic [DEN_W-1:0]           den;
   logic [DIV_W-1:0]           delta;
   logic [DIV_W-1:0]           delta_abs;
   logic [DEN_W:0]             trial;
   logic                       trial_ge;
   logic [DEN_W-1:0]           rem_in;
   logic [DEN_W:0]             sum_r;
   logic                       wrap;
   logic [DEN_W-1:0]           acc_r_in;
   logic [DIV_W-1:0]           acc_q_in;
   logic [DEN_W:0]             half_sum;
   logic [DIV_W-1:0]           q_round;
   logic [SAMPLE_W+1:0]        base;
   logic [SAMPLE_W+1:0]        interp_sum;
   logic [SAMPLE_W-1:0]        fill_value;
   logic [SAMPLE_W-1:0]        flush_value;
   logic                       flush_err;
   logic                       gap_full;
   logic                       fill_last;
   logic                       flush_last;
   logic                       slot_free;

   assign req_missing = mode_ff ? (req_sample == marker_ff) : req_is_nan;
   assign den         = DEN_W'(gap_ff) + DEN_W'(1);

   // Distance between the two neighbors of an inner gap, kept as sign and magnitude.
   assign delta     = {cur_ff[SAMPLE_W-1], cur_ff} - {last_ff[SAMPLE_W-1], last_ff};
   assign delta_abs = delta[DIV_W-1] ? (~delta + DIV_W'(1)) : delta;

   // One restoring divide step per cycle; the dividend register fills with quotient bits.
   assign trial    = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign trial_ge = trial >= {1'b0, den};
   assign rem_in   = trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

   // The accumulator holds i*|delta| as quotient and remainder over den.
   assign sum_r    = {1'b0, acc_r_ff} + {1'b0, div_rem_ff};
   assign wrap     = sum_r >= {1'b0, den};
   assign acc_r_in = wrap ? DEN_W'(sum_r - {1'b0, den}) : sum_r[DEN_W-1:0];
   assign acc_q_in = acc_q_ff + div_num_ff + DIV_W'(wrap);

   // Round half away from zero: bump the magnitude when remainder + den/2 reaches den.
   assign half_sum   = {1'b0, acc_r_ff} + {2'b00, den[DEN_W-1:1]};
   assign q_round    = acc_q_ff + DIV_W'(half_sum >= {1'b0, den});
   assign base       = {{2{last_ff[SAMPLE_W-1]}}, last_ff};
   assign interp_sum = neg_ff ? (base - {1'b0, q_round}) : (base + {1'b0, q_round});

   // A leading gap has no left neighbor and is filled flat with the closing sample.
   assign fill_value  = have_ff ? interp_sum[SAMPLE_W-1:0] : cur_ff;
   assign flush_value = have_ff ? last_ff : '0;
   assign gap_full    = gap_ff == GAP_W'(MAX_GAP);
   assign flush_err   = gap_full || !have_ff;
   assign fill_last   = ({1'b0, idx_ff} + DEN_W'(1)) == {1'b0, gap_ff};
   assign flush_last  = idx_ff == gap_ff;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.missing    = missing_ff;
      status.column_end = end_ff;
      status.have_valid = have_ff;
      status.gap_zero   = gap_ff == '0;
      status.gap_full   = gap_full;
      status.div_done   = div_cnt_ff == DIV_CNT_W'(DIV_W - 1);
      status.fill_last  = fill_last;
      status.flush_last = flush_last;
      status.slot_free  = slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         marker_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MARKER_MODE:  mode_ff   <= csr_wdata[0];
            CSR_MARKER_VALUE: marker_ff <= csr_wdata;
            default:          mode_ff   <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff     <= req_sample;
         end_ff     <= req_column_end;
         missing_ff <= req_missing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         have_ff <= 1'b0;
         gap_ff  <= '0;
      end else if (cmd.gap_inc) begin
         gap_ff <= gap_ff + GAP_W'(1);
      end else if (cmd.emit_cur) begin
         gap_ff  <= '0;
         last_ff <= end_ff ? '0 : cur_ff;
         have_ff <= !end_ff;
      end else if (cmd.emit_flush && flush_last) begin
         gap_ff <= '0;
         if (end_ff) begin
            last_ff <= '0;
            have_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= '0;
      end else if (cmd.emit_fill || cmd.emit_flush) begin
         idx_ff <= idx_ff + GAP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_num_ff <= delta_abs;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
         neg_ff     <= delta[DIV_W-1];
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[DIV_W-2:0], trial_ge};
         div_rem_ff <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         acc_q_ff <= div_num_ff;
         acc_r_ff <= div_rem_ff;
      end else if (cmd.emit_fill) begin
         acc_q_ff <= acc_q_in;
         acc_r_ff <= acc_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_fill || cmd.emit_cur || cmd.emit_flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fill) begin
         rsp_value_ff  <= fill_value;
         rsp_filled_ff <= 1'b1;
         rsp_error_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_done_ff   <= 1'b0;
      end else if (cmd.emit_cur) begin
         rsp_value_ff  <= cur_ff;
         rsp_filled_ff <= 1'b0;
         rsp_error_ff  <= 1'b0;
         rsp_last_ff   <= 1'b1;
         rsp_done_ff   <= end_ff;
      end else if (cmd.emit_flush) begin
         rsp_value_ff  <= flush_value;
         rsp_filled_ff <= 1'b1;
         rsp_error_ff  <= flush_err;
         rsp_last_ff   <= flush_last;
         rsp_done_ff   <= flush_last && end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_filled      = rsp_filled_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_column_done = rsp_done_ff;

endmodule

// ----- hdl/glif_ctrl.sv -----
module glif_ctrl import glif_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_DIV,
      S_PREP,
      S_FILL,
      S_CUR,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (status.missing) begin
               if (status.gap_full || status.column_end) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.gap_inc = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (status.gap_zero) begin
               if (status.slot_free) begin
                  cmd.emit_cur = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_CUR;
               end
            end else if (status.have_valid) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FILL;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.acc_load = 1'b1;
            state_in     = S_FILL;
         end
         S_FILL: begin
            if (status.slot_free) begin
               cmd.emit_fill = 1'b1;
               if (status.fill_last) begin
                  state_in = S_CUR;
               end
            end
         end
         S_CUR: begin
            if (status.slot_free) begin
               cmd.emit_cur = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (status.slot_free) begin
               cmd.emit_flush = 1'b1;
               if (status.flush_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

// ----- hdl/glif_checker.sv -----
module glif_checker import glif_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SAMPLE_W-1:0] rsp_value,
   input logic                rsp_filled,
   input logic                rsp_error,
   input logic                rsp_last_of_run,
   input logic                rsp_column_done
);

   // One item at a time: after an accept the input side must stall.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while previous item still in progress");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_done |-> rsp_last_of_run)
      else $error("column_done on an item that is not last of run");

   a_valid_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_filled |-> !rsp_error && rsp_last_of_run)
      else $error("original sample flagged as error or not last of run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_filled))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gap_linear_interpolation_fill glif_checker u_glif_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_value       (rsp_value),
   .rsp_filled      (rsp_filled),
   .rsp_error       (rsp_error),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_column_done (rsp_column_done)
);
